// File: hdl/deq_pkg.sv
`default_nettype none

package deq_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int DEPTH      = 16;
    localparam int OP_W       = 3;
    localparam int CNT_W      = 5;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_PEEK_FRONT = 3'd4;
    localparam logic [OP_W-1:0] OP_PEEK_BACK  = 3'd5;
    localparam logic [OP_W-1:0] OP_STATUS     = 3'd6;

    typedef struct packed {
        logic [OP_W-1:0]              op;
        logic signed [DATA_WIDTH-1:0] data_in;
    } t_req;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] data_out;
        logic [CNT_W-1:0]             count;
        logic                         is_empty;
        logic                         error;
    } t_rsp;

endpackage

`default_nettype wire

// File: hdl/deq_ram.sv
`default_nettype none

module deq_ram #(
    parameter int WIDTH = deq_pkg::DATA_WIDTH,
    parameter int DEPTH = deq_pkg::DEPTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: hdl/double_ended_queue.sv
`default_nettype none

// Double-ended queue over a circular store of DEPTH words (DEPTH up to 31, the most the 5-bit count holds).
// A request is taken whenever start is high and busy is low; busy is high only
// during reset, so a new request may follow in every cycle. Each request gives
// exactly one result word, marked by o_valid, in the cycle right after it was
// taken: the element popped or peeked comes from the storage RAM's registered
// read port. Head, tail and count are updated at acceptance, so back-to-back
// requests see each other's effect.
// Results cannot be held off and must be taken in the cycle they appear.
// A push into a full queue is dropped; a pop or peek on an empty queue returns
// all ones; both raise error.

module double_ended_queue #(
    parameter int DEPTH = deq_pkg::DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire deq_pkg::t_req i_req,
    output logic               o_valid,
    output deq_pkg::t_rsp      o_rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [deq_pkg::CNT_W-1:0] FULL_CNT = deq_pkg::CNT_W'(DEPTH);

    logic [AW-1:0]               r_head, n_head;
    logic [AW-1:0]               r_tail, n_tail;
    logic [deq_pkg::CNT_W-1:0]   r_count, n_count;
    logic                        r_valid;
    logic                        r_err, n_err;
    logic                        r_rd, n_rd;

    logic                        accept;
    logic                        empty, full;
    logic [AW-1:0]               head_up, head_dn, tail_up, tail_dn;
    logic                        we, re;
    logic [AW-1:0]               waddr, raddr;
    logic [deq_pkg::DATA_WIDTH-1:0] rdata;

    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;
    assign empty  = (r_count == '0);
    assign full   = (r_count == FULL_CNT);

    assign head_up = (r_head == LAST) ? '0 : r_head + AW'(1);
    assign head_dn = (r_head == '0) ? LAST : r_head - AW'(1);
    assign tail_up = (r_tail == LAST) ? '0 : r_tail + AW'(1);
    assign tail_dn = (r_tail == '0) ? LAST : r_tail - AW'(1);

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        n_err   = 1'b0;
        n_rd    = 1'b0;
        we      = 1'b0;
        re      = 1'b0;
        waddr   = r_tail;
        raddr   = r_head;
        if (accept) begin
            case (i_req.op)
                deq_pkg::OP_PUSH_FRONT: begin
                    if (full) begin
                        n_err = 1'b1;
                    end else begin
                        we      = 1'b1;
                        waddr   = head_dn;
                        n_head  = head_dn;
                        n_count = r_count + 1'b1;
                    end
                end
                deq_pkg::OP_PUSH_BACK: begin
                    if (full) begin
                        n_err = 1'b1;
                    end else begin
                        we      = 1'b1;
                        waddr   = r_tail;
                        n_tail  = tail_up;
                        n_count = r_count + 1'b1;
                    end
                end
                deq_pkg::OP_POP_FRONT: begin
                    if (empty) begin
                        n_err = 1'b1;
                    end else begin
                        re      = 1'b1;
                        n_rd    = 1'b1;
                        raddr   = r_head;
                        n_head  = head_up;
                        n_count = r_count - 1'b1;
                    end
                end
                deq_pkg::OP_POP_BACK: begin
                    if (empty) begin
                        n_err = 1'b1;
                    end else begin
                        re      = 1'b1;
                        n_rd    = 1'b1;
                        raddr   = tail_dn;
                        n_tail  = tail_dn;
                        n_count = r_count - 1'b1;
                    end
                end
                deq_pkg::OP_PEEK_FRONT: begin
                    if (empty) begin
                        n_err = 1'b1;
                    end else begin
                        re    = 1'b1;
                        n_rd  = 1'b1;
                        raddr = r_head;
                    end
                end
                deq_pkg::OP_PEEK_BACK: begin
                    if (empty) begin
                        n_err = 1'b1;
                    end else begin
                        re    = 1'b1;
                        n_rd  = 1'b1;
                        raddr = tail_dn;
                    end
                end
                default: begin
                    // status and the unused code change nothing
                end
            endcase
        end
    end

    deq_ram #(
        .WIDTH (deq_pkg::DATA_WIDTH),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_req.data_in),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
            r_err   <= 1'b0;
            r_rd    <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_valid <= accept;
            r_err   <= n_err;
            r_rd    <= n_rd;
        end
    end

    // r_count already holds the post-request count in the result cycle
    assign o_valid        = r_valid;
    assign o_rsp.data_out = r_rd ? rdata : '1;
    assign o_rsp.count    = r_count;
    assign o_rsp.is_empty = (r_count == '0);
    assign o_rsp.error    = r_err;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("element count above capacity");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_valid)
        else $error("request gave no result word");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> !o_valid)
        else $error("result word without request");

    a_err_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.error) |-> (o_rsp.data_out == '1))
        else $error("error result carries element data");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_count == $past(r_count) || r_count == $past(r_count) + 1'b1
                    || r_count == $past(r_count) - 1'b1))
        else $error("count moved by more than one");

endmodule

`default_nettype wire
